// File: design/wns_pkg.sv
// shared types and constants for the weighted neighbor select block
`timescale 1ns / 1ps

package wns_pkg;

  localparam int NEIGHBOR_COUNT = 6;
  localparam int AFF_W          = 16;
  localparam int FRAC_BITS      = 16;
  localparam int IDX_W          = 3;
  localparam int RUN_W          = AFF_W + $clog2(NEIGHBOR_COUNT);

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  // register indexes, at byte address 4 * index
  localparam int REG_AFF_HIGH = 0;
  localparam int REG_AFF_LOW  = 1;

  localparam logic [AFF_W-1:0] AFF_HIGH_RESET = 16'd52429;
  localparam logic [AFF_W-1:0] AFF_LOW_RESET  = 16'd13107;

  typedef logic [AFF_W-1:0] weight_t;
  typedef logic [RUN_W-1:0] run_t;

  typedef struct packed {
    logic                      valid;
    logic [NEIGHBOR_COUNT-1:0] mask;
    logic                      window_ok;
  } wns_ctl_t;

endpackage

// File: design/weighted_neighbor_select_core.sv
// top level of the weighted neighbor select block
`timescale 1ns / 1ps

// Roulette-wheel choice of one of six neighbors by clamped affinity. A request
// is taken on every cycle with start high; busy never rises, so requests may
// follow back to back. Each request gives exactly one result, shown for one cycle
// with out_valid high; the receiver cannot stall it. A request passes through
// registered stages in order: the lane clamp, the prefix-sum adder chain,
// the total-times-random multiplier and the lane compare with priority merge.
// affinity_high sits at byte address 0 and affinity_low at 4; write them only
// while no request is in flight.

module weighted_neighbor_select_core
  import wns_pkg::*;
#(
  parameter int FRACTION_BITS = FRAC_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  weight_t                   in_weight_in_0,
  input  weight_t                   in_weight_in_1,
  input  weight_t                   in_weight_in_2,
  input  weight_t                   in_weight_in_3,
  input  weight_t                   in_weight_in_4,
  input  weight_t                   in_weight_in_5,
  input  logic [NEIGHBOR_COUNT-1:0] in_present_mask,
  input  logic [FRACTION_BITS-1:0]  in_random_fraction,
  output logic                      out_valid,
  output logic [IDX_W-1:0]          out_chosen_index,
  output logic                      out_choice_found,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [CFG_ADDR_W-1:0]     paddr,
  input  logic [CFG_DATA_W-1:0]     pwdata,
  output logic [CFG_DATA_W-1:0]     prdata,
  output logic                      pready
);

  weight_t affinity_high_r;
  weight_t affinity_low_r;
  logic    cfg_write;
  logic    addr_ok;
  logic    reg_sel;

  weight_t                        affinity [NEIGHBOR_COUNT];
  weight_t                        weight   [NEIGHBOR_COUNT];
  run_t                           run_sum  [NEIGHBOR_COUNT];
  logic [RUN_W+FRACTION_BITS-1:0] threshold;
  logic [NEIGHBOR_COUNT-1:0]      hits;
  wns_ctl_t                       ctl1_r;
  wns_ctl_t                       ctl_cmp;
  logic [FRACTION_BITS-1:0]       rand1_r;
  logic                           accept;

  // configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_sel   = paddr[2];
  assign addr_ok   = (paddr[1:0] == 2'b00);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      affinity_high_r <= AFF_HIGH_RESET;
      affinity_low_r  <= AFF_LOW_RESET;
    end else if (cfg_write) begin
      unique case (reg_sel)
        1'(REG_AFF_HIGH): affinity_high_r <= pwdata[AFF_W-1:0];
        1'(REG_AFF_LOW):  affinity_low_r  <= pwdata[AFF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (addr_ok) begin
      unique case (reg_sel)
        1'(REG_AFF_HIGH): prdata = CFG_DATA_W'(affinity_high_r);
        1'(REG_AFF_LOW):  prdata = CFG_DATA_W'(affinity_low_r);
        default:          prdata = '0;
      endcase
    end
  end

  // request side, no backpressure
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign affinity[0] = in_weight_in_0;
  assign affinity[1] = in_weight_in_1;
  assign affinity[2] = in_weight_in_2;
  assign affinity[3] = in_weight_in_3;
  assign affinity[4] = in_weight_in_4;
  assign affinity[5] = in_weight_in_5;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r.valid <= 1'b0;
    end else begin
      ctl1_r.valid <= accept;
    end
    ctl1_r.mask      <= in_present_mask;
    ctl1_r.window_ok <= affinity_low_r < affinity_high_r;
    rand1_r          <= in_random_fraction;
  end

  for (genvar g = 0; g < NEIGHBOR_COUNT; g++) begin : g_lane
    wns_lane #(
      .FRACTION_BITS (FRACTION_BITS)
    ) u_lane (
      .clk       (clk),
      .affinity  (affinity[g]),
      .present   (in_present_mask[g]),
      .aff_low   (affinity_low_r),
      .aff_high  (affinity_high_r),
      .weight_r  (weight[g]),
      .run_sum   (run_sum[g]),
      .threshold (threshold),
      .hit       (hits[g])
    );
  end

  wns_wheel #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_wheel (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl_in        (ctl1_r),
    .rand_in       (rand1_r),
    .weight        (weight),
    .ctl_out       (ctl_cmp),
    .run_out       (run_sum),
    .threshold_out (threshold)
  );

  wns_merge u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl_in      (ctl_cmp),
    .hits        (hits),
    .out_valid_r (out_valid),
    .out_index_r (out_chosen_index),
    .out_found_r (out_choice_found)
  );

endmodule

// File: design/wns_lane.sv
// one neighbor lane: window clamp of the affinity and running-sum compare
`timescale 1ns / 1ps

module wns_lane
  import wns_pkg::*;
#(
  parameter int FRACTION_BITS = FRAC_BITS
) (
  input  logic                           clk,
  input  weight_t                        affinity,
  input  logic                           present,
  input  weight_t                        aff_low,
  input  weight_t                        aff_high,
  output weight_t                        weight_r,
  input  run_t                           run_sum,
  input  logic [RUN_W+FRACTION_BITS-1:0] threshold,
  output logic                           hit
);

  weight_t clamped;
  weight_t weight_nxt;

  always_comb begin
    clamped = affinity;
    if (clamped > aff_high) begin
      clamped = aff_high;
    end
    if (clamped < aff_low) begin
      clamped = aff_low;
    end
    weight_nxt = present ? weight_t'(clamped - aff_low) : '0;
  end

  always_ff @(posedge clk) begin
    weight_r <= weight_nxt;
  end

  // run * 2^fraction_bits against total * r, exact
  assign hit = {run_sum, {FRACTION_BITS{1'b0}}} > threshold;

endmodule

// File: design/wns_wheel.sv
// prefix sums of the lane weights and the total times random threshold
`timescale 1ns / 1ps

module wns_wheel
  import wns_pkg::*;
#(
  parameter int FRACTION_BITS = FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  wns_ctl_t                       ctl_in,
  input  logic [FRACTION_BITS-1:0]       rand_in,
  input  weight_t                        weight [NEIGHBOR_COUNT],
  output wns_ctl_t                       ctl_out,
  output run_t                           run_out [NEIGHBOR_COUNT],
  output logic [RUN_W+FRACTION_BITS-1:0] threshold_out
);

  run_t                     run_nxt [NEIGHBOR_COUNT];
  run_t                     run2_r  [NEIGHBOR_COUNT];
  run_t                     run3_r  [NEIGHBOR_COUNT];
  wns_ctl_t                 ctl2_r;
  wns_ctl_t                 ctl3_r;
  logic [FRACTION_BITS-1:0] rand2_r;
  logic [RUN_W+FRACTION_BITS-1:0] threshold_r;

  always_comb begin
    run_nxt[0] = run_t'(weight[0]);
    for (int i = 1; i < NEIGHBOR_COUNT; i++) begin
      run_nxt[i] = run_nxt[i-1] + run_t'(weight[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl2_r.valid <= 1'b0;
      ctl3_r.valid <= 1'b0;
    end else begin
      ctl2_r.valid <= ctl_in.valid;
      ctl3_r.valid <= ctl2_r.valid;
    end
    ctl2_r.mask      <= ctl_in.mask;
    ctl2_r.window_ok <= ctl_in.window_ok;
    ctl3_r.mask      <= ctl2_r.mask;
    ctl3_r.window_ok <= ctl2_r.window_ok;
    rand2_r          <= rand_in;
    run2_r           <= run_nxt;
    run3_r           <= run2_r;
    // last running sum is the total
    threshold_r      <= (RUN_W+FRACTION_BITS)'(run2_r[NEIGHBOR_COUNT-1]) *
                        (RUN_W+FRACTION_BITS)'(rand2_r);
  end

  assign ctl_out       = ctl3_r;
  assign run_out       = run3_r;
  assign threshold_out = threshold_r;

endmodule

// File: design/wns_merge.sv
// picks the first qualifying lane and registers the result
`timescale 1ns / 1ps

module wns_merge
  import wns_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  wns_ctl_t                  ctl_in,
  input  logic [NEIGHBOR_COUNT-1:0] hits,
  output logic                      out_valid_r,
  output logic [IDX_W-1:0]          out_index_r,
  output logic                      out_found_r
);

  logic [NEIGHBOR_COUNT-1:0] qual;
  logic [IDX_W-1:0]          index_nxt;
  logic                      found_nxt;

  always_comb begin
    qual      = ctl_in.window_ok ? (hits & ctl_in.mask) : '0;
    index_nxt = '0;
    found_nxt = 1'b0;
    // walk down so the lowest qualifying lane wins
    for (int i = NEIGHBOR_COUNT - 1; i >= 0; i--) begin
      if (qual[i]) begin
        index_nxt = IDX_W'(i);
        found_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl_in.valid;
    end
    out_index_r <= index_nxt;
    out_found_r <= found_nxt;
  end

endmodule
